### rtl/rmbh_pkg.sv
package rmbh_pkg;

    localparam int MAX_BOXES   = 32;
    localparam int BOX_IDX_W   = $clog2(MAX_BOXES);
    localparam int BOX_CNT_W   = 6;
    localparam int ANGLE_STEPS = 1024;
    localparam int ANG_W       = $clog2(ANGLE_STEPS);
    localparam int QTR         = ANGLE_STEPS / 4;
    localparam int QTR_W       = ANG_W - 2;
    localparam int ONE_Q14     = 16384;

    localparam int STEP_W  = 12;
    localparam int COUNT_W = 8;
    localparam int DIST_W  = 20;
    localparam int POS_W   = 18;
    localparam int TRIG_W  = 16;
    localparam int INC_W   = TRIG_W + STEP_W + 1;
    localparam int ACC_W   = 36;
    localparam int PT_W    = 24;
    localparam int CFG_W   = 12;

    localparam logic [0:0] OP_BOX_WRITE = 1'b0;
    localparam logic [0:0] OP_CAST      = 1'b1;

    localparam logic [1:0] REG_STEP_SIZE  = 2'd0;
    localparam logic [1:0] REG_STEP_COUNT = 2'd1;
    localparam logic [1:0] REG_BOX_COUNT  = 2'd2;

    localparam logic [STEP_W-1:0]    STEP_SIZE_RST  = STEP_W'(128);
    localparam logic [COUNT_W-1:0]   STEP_COUNT_RST = COUNT_W'(100);
    localparam logic [BOX_CNT_W-1:0] BOX_COUNT_RST  = BOX_CNT_W'(20);

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    // pi split over the angle steps: quotient and remainder
    localparam logic [63:0] PI_STEP_QUO = PI_Q62 / ANGLE_STEPS;
    localparam logic [63:0] PI_STEP_REM = PI_Q62 % ANGLE_STEPS;

    typedef struct packed {
        logic [9:0] left;
        logic [9:0] top;
        logic [6:0] width;
        logic [6:0] height;
    } box_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [DIST_W-1:0] distance;
    } march_res_t;

    typedef logic [QTR-1:0][14:0] qtr_tab_t;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // restoring division, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
            rem = {rem[63:0], num[bit_pos]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[bit_pos] = 1'b1;
            end
        end
        return quo;
    endfunction

    // quarter-wave sine, Q1.14, round half away from zero (elaboration only)
    function automatic qtr_tab_t build_qtr();
        qtr_tab_t    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] dv;
        logic [63:0] rnd;
        logic [63:0] a;
        for (int k = 0; k < QTR; k++) begin
            a = 64'(2 * k);
            x = PI_STEP_QUO * a + (PI_STEP_REM * a) / ANGLE_STEPS;
            x2 = mul_q62(x, x);
            term = x;
            sum = x;
            for (int n = 1; n < 40; n++) begin
                if (term != 64'd0) begin
                    dv = 64'((2 * n) * (2 * n + 1));
                    term = udiv64(mul_q62(term, x2), dv);
                    if ((n % 2) == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
            end
            rnd = (sum + (64'd1 << 47)) >> 48;
            tab[k] = rnd[14:0];
        end
        return tab;
    endfunction

    localparam qtr_tab_t SIN_QTR = build_qtr();

    function automatic logic signed [TRIG_W-1:0] sin_lookup(input logic [ANG_W-1:0] k);
        logic [QTR_W-1:0]         r;
        logic [14:0]              mag;
        logic signed [TRIG_W-1:0] v;
        r = k[QTR_W-1:0];
        if (k[QTR_W]) begin
            if (r == '0)
                mag = 15'(ONE_Q14);
            else
                mag = SIN_QTR[QTR_W'(QTR - int'(r))];
        end
        else begin
            mag = SIN_QTR[r];
        end
        v = $signed({1'b0, mag});
        if (k[QTR_W + 1])
            v = -v;
        return v;
    endfunction

endpackage

### rtl/rmbh_box_ram.sv
module rmbh_box_ram
    import rmbh_pkg::*;
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [BOX_IDX_W-1:0] wr_addr,
    input  box_t                 wr_data,
    input  logic                 rd_en,
    input  logic [BOX_IDX_W-1:0] rd_addr,
    output box_t                 rd_data
);

    box_t mem [MAX_BOXES];
    box_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rmbh_dir.sv
module rmbh_dir
    import rmbh_pkg::*;
(
    input  logic                     clk,
    input  logic [ANG_W-1:0]         angle,
    input  logic [STEP_W-1:0]        step_size,
    output logic signed [INC_W-1:0]  inc_x,
    output logic signed [INC_W-1:0]  inc_y
);

    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [INC_W-1:0]  inc_x_reg;
    logic signed [INC_W-1:0]  inc_y_reg;
    logic [ANG_W-1:0]         cos_angle;
    logic signed [STEP_W:0]   step_s;

    // cos(k) = sin(k + quarter turn)
    assign cos_angle = ANG_W'(angle + ANG_W'(QTR));
    assign step_s    = $signed({1'b0, step_size});

    always_ff @(posedge clk)
    begin
        cos_reg   <= sin_lookup(cos_angle);
        sin_reg   <= sin_lookup(angle);
        inc_x_reg <= INC_W'(cos_reg * step_s);
        inc_y_reg <= INC_W'(sin_reg * step_s);
    end

    assign inc_x = inc_x_reg;
    assign inc_y = inc_y_reg;

endmodule

### rtl/rmbh_march.sv
module rmbh_march
    import rmbh_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [POS_W-1:0]  origin_x,
    input  logic signed [POS_W-1:0]  origin_y,
    input  logic [ANG_W-1:0]         angle_code,
    input  logic [STEP_W-1:0]        step_size,
    input  logic [COUNT_W-1:0]       step_count,
    input  logic [BOX_CNT_W-1:0]     box_count,
    input  logic                     out_free,
    output logic [ANG_W-1:0]         dir_angle,
    input  logic signed [INC_W-1:0]  inc_x,
    input  logic signed [INC_W-1:0]  inc_y,
    output logic                     rd_en,
    output logic [BOX_IDX_W-1:0]     rd_addr,
    input  box_t                     rd_data,
    output logic                     idle,
    output march_res_t               res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIG,
        S_MUL,
        S_POINT,
        S_TEST,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic signed [POS_W-1:0]  ox_reg;
    logic signed [POS_W-1:0]  oy_reg;
    logic [ANG_W-1:0]         angle_reg;
    logic signed [ACC_W-1:0]  acc_x_reg;
    logic signed [ACC_W-1:0]  acc_y_reg;
    logic signed [PT_W-1:0]   px_reg;
    logic signed [PT_W-1:0]   py_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic [COUNT_W-1:0]       i_reg;
    logic [BOX_CNT_W-1:0]     j_reg;
    logic                     hit_reg;

    logic [BOX_CNT_W-1:0]     nbox;
    logic [BOX_CNT_W-1:0]     j_inc;
    logic                     last_sample;
    logic                     in_box;
    logic signed [PT_W-1:0]   px_next;
    logic signed [PT_W-1:0]   py_next;
    logic signed [PT_W-1:0]   lo_x;
    logic signed [PT_W-1:0]   hi_x;
    logic signed [PT_W-1:0]   lo_y;
    logic signed [PT_W-1:0]   hi_y;

    assign nbox  = (box_count > BOX_CNT_W'(MAX_BOXES)) ? BOX_CNT_W'(MAX_BOXES) : box_count;
    assign j_inc = BOX_CNT_W'(j_reg + 1'b1);
    assign last_sample = ({1'b0, i_reg} + 9'd1) == {1'b0, step_count};

    // arithmetic shift is the floor division by 2^14
    assign px_next = PT_W'(ox_reg) + PT_W'(acc_x_reg >>> 14);
    assign py_next = PT_W'(oy_reg) + PT_W'(acc_y_reg >>> 14);

    assign lo_x = $signed(PT_W'({rd_data.left, 6'b0}));
    assign hi_x = $signed(PT_W'({11'(rd_data.left) + 11'(rd_data.width), 6'b0}));
    assign lo_y = $signed(PT_W'({rd_data.top, 6'b0}));
    assign hi_y = $signed(PT_W'({11'(rd_data.top) + 11'(rd_data.height), 6'b0}));

    assign in_box = (px_reg >= lo_x) && (px_reg <= hi_x) && (py_reg >= lo_y) && (py_reg <= hi_y);

    // box read is issued in the cycle before its test
    assign rd_en   = (state_reg == S_POINT) || (state_reg == S_TEST);
    assign rd_addr = (state_reg == S_TEST) ? j_inc[BOX_IDX_W-1:0] : '0;

    assign dir_angle    = angle_reg;
    assign idle         = (state_reg == S_IDLE);
    assign res.valid    = (state_reg == S_DONE) && out_free;
    assign res.hit      = hit_reg;
    assign res.distance = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ox_reg    <= '0;
            oy_reg    <= '0;
            angle_reg <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            dist_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        ox_reg    <= origin_x;
                        oy_reg    <= origin_y;
                        angle_reg <= angle_code;
                        acc_x_reg <= '0;
                        acc_y_reg <= '0;
                        dist_reg  <= '0;
                        i_reg     <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= (step_count == '0) ? S_DONE : S_TRIG;
                    end
                end
                S_TRIG:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_POINT;
                end
                S_POINT:
                begin
                    px_reg <= px_next;
                    py_reg <= py_next;
                    j_reg  <= '0;
                    if (nbox == '0)
                    begin
                        dist_reg  <= DIST_W'(dist_reg + step_size);
                        acc_x_reg <= acc_x_reg + ACC_W'(inc_x);
                        acc_y_reg <= acc_y_reg + ACC_W'(inc_y);
                        i_reg     <= COUNT_W'(i_reg + 1'b1);
                        state_reg <= last_sample ? S_DONE : S_POINT;
                    end
                    else
                    begin
                        state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    if (in_box)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (j_inc == nbox)
                    begin
                        dist_reg  <= DIST_W'(dist_reg + step_size);
                        acc_x_reg <= acc_x_reg + ACC_W'(inc_x);
                        acc_y_reg <= acc_y_reg + ACC_W'(inc_y);
                        i_reg     <= COUNT_W'(i_reg + 1'b1);
                        state_reg <= last_sample ? S_DONE : S_POINT;
                    end
                    else
                    begin
                        j_reg <= j_inc;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/ray_march_box_hit_distance_unit.sv
// Fixed-step 2-D ray marcher against a table of up to 32 axis-aligned boxes.
// Input channel (in_valid/in_ready) carries two kinds of transaction:
//   box write (opcode 0): stores one rectangle in slot box_index and produces
//     no result.
//   cast (opcode 1): marches from origin_x/origin_y along angle_code and
//     produces exactly one result transaction (hit, distance).
// Output channel (out_valid/out_ready) is a single output register.
// A cast forms each sample point and then tests it against the boxes one at a
// time, boxes being box_count limited to 32, since the box table has a single
// read port. A hit ends the march early.
// The input is taken only when no cast is running.
// If the receiver stalls, a finished cast waits in the marcher until the output
// register frees up; a pending result also blocks box writes. The user must
// write configuration (cfg_write/cfg_index/cfg_data) only while idle; the block
// does not enforce it. Reset restores step_size 128, step_count 100, box_count
// 20 and clears the handshake state; box table contents are undefined until written.
module ray_march_box_hit_distance_unit
    import rmbh_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [0:0]               opcode,
    input  logic [BOX_IDX_W-1:0]     box_index,
    input  logic [9:0]               box_left,
    input  logic [9:0]               box_top,
    input  logic [6:0]               box_width,
    input  logic [6:0]               box_height,
    input  logic signed [POS_W-1:0]  origin_x,
    input  logic signed [POS_W-1:0]  origin_y,
    input  logic [ANG_W-1:0]         angle_code,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [DIST_W-1:0]        distance
);

    logic [STEP_W-1:0]    step_size_reg;
    logic [COUNT_W-1:0]   step_count_reg;
    logic [BOX_CNT_W-1:0] box_count_reg;
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [DIST_W-1:0]    distance_reg;

    logic                     in_fire;
    logic                     start;
    logic                     box_wr;
    box_t                     box_wr_data;
    logic                     out_free;
    logic                     idle;
    march_res_t               res;
    logic [ANG_W-1:0]         dir_angle;
    logic signed [INC_W-1:0]  inc_x;
    logic signed [INC_W-1:0]  inc_y;
    logic                     rd_en;
    logic [BOX_IDX_W-1:0]     rd_addr;
    box_t                     rd_data;

    assign in_ready = idle;
    assign in_fire  = in_valid && in_ready;
    assign start    = in_fire && (opcode == OP_CAST);
    assign box_wr   = in_fire && (opcode == OP_BOX_WRITE);
    assign out_free = !out_valid_reg || out_ready;

    assign box_wr_data.left   = box_left;
    assign box_wr_data.top    = box_top;
    assign box_wr_data.width  = box_width;
    assign box_wr_data.height = box_height;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= STEP_SIZE_RST;
            step_count_reg <= STEP_COUNT_RST;
            box_count_reg  <= BOX_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STEP_SIZE:  step_size_reg  <= cfg_data[STEP_W-1:0];
                REG_STEP_COUNT: step_count_reg <= cfg_data[COUNT_W-1:0];
                REG_BOX_COUNT:  box_count_reg  <= cfg_data[BOX_CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            distance_reg  <= '0;
        end
        else
        begin
            if (res.valid)
            begin
                out_valid_reg <= 1'b1;
                hit_reg       <= res.hit;
                distance_reg  <= res.distance;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign distance  = distance_reg;

    rmbh_box_ram u_box_ram (
        .clk     (clk),
        .wr_en   (box_wr),
        .wr_addr (box_index),
        .wr_data (box_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rmbh_dir u_dir (
        .clk       (clk),
        .angle     (dir_angle),
        .step_size (step_size_reg),
        .inc_x     (inc_x),
        .inc_y     (inc_y)
    );

    rmbh_march u_march (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .angle_code (angle_code),
        .step_size  (step_size_reg),
        .step_count (step_count_reg),
        .box_count  (box_count_reg),
        .out_free   (out_free),
        .dir_angle  (dir_angle),
        .inc_x      (inc_x),
        .inc_y      (inc_y),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .idle       (idle),
        .res        (res)
    );

endmodule

### test/ray_march_box_hit_distance_unit_tb.sv
module ray_march_box_hit_distance_unit_tb;
    import rmbh_pkg::*;

    localparam int  CYCLE_LIMIT = 2000000;
    localparam real PI          = 3.14159265358979323846;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } ray_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [1:0]              cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [0:0]              opcode;
    logic [BOX_IDX_W-1:0]    box_index;
    logic [9:0]              box_left;
    logic [9:0]              box_top;
    logic [6:0]              box_width;
    logic [6:0]              box_height;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic [ANG_W-1:0]        angle_code;
    logic                    out_valid;
    logic                    out_ready;
    logic                    hit;
    logic [DIST_W-1:0]       distance;

    // shadow of the block: configuration, box table, Q1.14 trig tables
    logic [STEP_W-1:0]    cfg_step_size;
    logic [COUNT_W-1:0]   cfg_step_count;
    logic [BOX_CNT_W-1:0] cfg_box_count;
    box_t                 box_store [MAX_BOXES];
    int                   sin_q14 [ANGLE_STEPS];
    int                   cos_q14 [ANGLE_STEPS];

    ray_result_t expected_rays [$];
    ray_result_t head_ray;
    int          error_count;
    int          burst_left;
    logic [15:0] stall_pattern;
    int          stall_pos;

    ray_march_box_hit_distance_unit DUT (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int round_q14(input real v);
        real scaled;
        scaled = v * 16384.0;
        if (scaled >= 0.0)
            return $rtoi(scaled + 0.5);
        return -$rtoi(-scaled + 0.5);
    endfunction

    function automatic ray_result_t trace_ray(input logic signed [POS_W-1:0] ox,
                                              input logic signed [POS_W-1:0] oy,
                                              input logic [ANG_W-1:0] ang);
        ray_result_t res;
        longint      c;
        longint      s;
        longint      sample_dist;
        longint      px;
        longint      py;
        longint      total;
        int          nb;
        box_t        b;
        c = cos_q14[ang];
        s = sin_q14[ang];
        nb = (cfg_box_count > MAX_BOXES) ? MAX_BOXES : int'(cfg_box_count);
        for (int i = 0; i < int'(cfg_step_count); i++)
        begin
            sample_dist = longint'(i) * longint'(cfg_step_size);
            // floor division by 2^14 is an arithmetic shift
            px = longint'(ox) + ((c * sample_dist) >>> 14);
            py = longint'(oy) + ((s * sample_dist) >>> 14);
            for (int j = 0; j < nb; j++)
            begin
                b = box_store[j];
                if (px >= longint'(b.left) * 64
                    && px <= (longint'(b.left) + longint'(b.width)) * 64
                    && py >= longint'(b.top) * 64
                    && py <= (longint'(b.top) + longint'(b.height)) * 64)
                begin
                    res.hit = 1'b1;
                    res.distance = DIST_W'(sample_dist);
                    return res;
                end
            end
        end
        total = longint'(cfg_step_count) * longint'(cfg_step_size);
        res.hit = 1'b0;
        res.distance = DIST_W'(total);
        return res;
    endfunction

    // caller is just past a rising edge; returns at the edge that accepts the transaction
    task automatic send_item(input logic [0:0] op, input logic [BOX_IDX_W-1:0] idx,
                             input box_t b, input logic signed [POS_W-1:0] ox,
                             input logic signed [POS_W-1:0] oy, input logic [ANG_W-1:0] ang);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 8);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        box_index  <= idx;
        box_left   <= b.left;
        box_top    <= b.top;
        box_width  <= b.width;
        box_height <= b.height;
        origin_x   <= ox;
        origin_y   <= oy;
        angle_code <= ang;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op == OP_CAST)
            expected_rays.push_back(trace_ray(ox, oy, ang));
        else
            box_store[idx] = b;
        burst_left--;
    endtask

    task automatic send_box_write(input int idx, input box_t b);
        send_item(OP_BOX_WRITE, BOX_IDX_W'(idx), b, POS_W'($urandom), POS_W'($urandom),
                  ANG_W'($urandom));
    endtask

    task automatic send_cast(input logic signed [POS_W-1:0] ox,
                             input logic signed [POS_W-1:0] oy, input int ang);
        box_t junk;
        junk = box_t'($urandom);
        send_item(OP_CAST, BOX_IDX_W'($urandom), junk, ox, oy, ANG_W'(ang));
    endtask

    task automatic send_random_cast();
        send_cast(POS_W'($urandom), POS_W'($urandom), $urandom_range(0, ANGLE_STEPS - 1));
    endtask

    // pick a point inside an active box and back off along a random heading,
    // so the march crosses the box somewhere inside its length
    task automatic send_aimed_cast();
        int   nb;
        int   j;
        int   ang;
        int   len;
        int   d;
        box_t b;
        real  theta;
        real  fx;
        real  fy;
        nb = (cfg_box_count > MAX_BOXES) ? MAX_BOXES : int'(cfg_box_count);
        if (nb == 0)
        begin
            send_random_cast();
            return;
        end
        j = $urandom_range(0, nb - 1);
        b = box_store[j];
        len = int'(cfg_step_count) * int'(cfg_step_size);
        d = $urandom_range(0, len);
        ang = $urandom_range(0, ANGLE_STEPS - 1);
        theta = 2.0 * PI * ang / ANGLE_STEPS;
        fx = real'(int'(b.left) * 64 + $urandom_range(0, int'(b.width) * 64))
             - $cos(theta) * d;
        fy = real'(int'(b.top) * 64 + $urandom_range(0, int'(b.height) * 64))
             - $sin(theta) * d;
        if (fx > 131071.0)
            fx = 131071.0;
        if (fx < -131072.0)
            fx = -131072.0;
        if (fy > 131071.0)
            fy = 131071.0;
        if (fy < -131072.0)
            fy = -131072.0;
        send_cast(POS_W'($rtoi(fx)), POS_W'($rtoi(fy)), ang);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_rays.size() != 0)
            @(posedge clk);
        // a trailing box write may still be in flight
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        case (idx)
            REG_STEP_SIZE:  cfg_step_size  = STEP_W'(value);
            REG_STEP_COUNT: cfg_step_count = COUNT_W'(value);
            REG_BOX_COUNT:  cfg_box_count  = BOX_CNT_W'(value);
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(input int step, input int count, input int boxes);
        wait_drained();
        write_register(REG_STEP_SIZE, step);
        write_register(REG_STEP_COUNT, count);
        write_register(REG_BOX_COUNT, boxes);
    endtask

    task automatic run_traffic_phase(input int n_items);
        int   r;
        box_t b;
        for (int n = 0; n < n_items; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                b = box_t'($urandom);
                send_box_write($urandom_range(0, MAX_BOXES - 1), b);
            end
            else if (r < 80)
                send_aimed_cast();
            else
                send_random_cast();
        end
    endtask

    // every slot is written before the first cast so no read hits an empty slot
    task automatic load_box_table();
        box_t b;
        for (int j = 0; j < MAX_BOXES; j++)
        begin
            b = box_t'($urandom);
            if (j == 0)
                b = '0;
            else if (j == 1)
                b = '{left: 10'd1023, top: 10'd1023, width: 7'd127, height: 7'd127};
            else if (j == 2)
                b = '{left: 10'd100, top: 10'd100, width: 7'd50, height: 7'd20};
            send_box_write(j, b);
        end
    endtask

    task automatic test_directed_rays();
        box_t b;
        // defaults: point box at the origin, then a far corner start
        send_cast(POS_W'(0), POS_W'(0), 0);
        send_cast(-POS_W'(131072), POS_W'(131071), ANGLE_STEPS - 1);
        // flat line box, reached after a few steps along +x
        b = '{left: 10'd200, top: 10'd300, width: 7'd127, height: 7'd0};
        send_box_write(2, b);
        send_cast(POS_W'(200 * 64 - 640), POS_W'(300 * 64), 0);
        // longest march, full distance on a miss
        apply_config(4095, 255, 1);
        send_cast(POS_W'(131071), POS_W'(131071), ANGLE_STEPS / 2);
        send_cast(-POS_W'(640), POS_W'(0), 0);
        // zero step size: every sample sits on the origin
        apply_config(0, 5, 3);
        send_cast(POS_W'(200 * 64 + 64), POS_W'(300 * 64), 100);
        send_cast(POS_W'(64), POS_W'(64), 300);
        // zero step count: no samples even from inside a box
        apply_config(64, 0, 3);
        send_cast(POS_W'(0), POS_W'(0), 0);
        // no boxes active
        apply_config(64, 40, 0);
        send_cast(POS_W'(0), POS_W'(0), 0);
        // box count above table size saturates to the full table
        apply_config(64, 200, 63);
        send_cast(POS_W'(1000 * 64), POS_W'(1050 * 64), 0);
        send_cast(POS_W'(200 * 64 + 100), POS_W'(300 * 64 - 3200), ANGLE_STEPS / 4);
        send_cast(POS_W'(int'(box_store[31].left) * 64), POS_W'(int'(box_store[31].top) * 64),
                  3 * ANGLE_STEPS / 4);
        send_cast(POS_W'(400 * 64), POS_W'(400 * 64), 3 * ANGLE_STEPS / 8);
    endtask

    task automatic test_random_traffic();
        int step;
        int count;
        int boxes;
        for (int p = 0; p < 10; p++)
        begin
            step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(8, 400);
            count = $urandom_range(1, 32);
            boxes = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                 : $urandom_range(1, 24);
            apply_config(step, count, boxes);
            run_traffic_phase(28);
        end
    endtask

    task automatic test_long_rays();
        apply_config($urandom_range(2048, 4095), 255, 63);
        run_traffic_phase(6);
    endtask

    // receiver: stall pattern re-drawn at the end of each 16-bit pattern, and result checking
    initial
    begin
        out_ready = 1'b0;
        stall_pattern = 16'hFFFF;
        stall_pos = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_rays.size() == 0)
                begin
                    $error("result with no cast pending: hit %0d distance %0d", hit, distance);
                    error_count++;
                end
                else
                begin
                    head_ray = expected_rays.pop_front();
                    if (hit !== head_ray.hit)
                    begin
                        $error("hit: expected %0d actual %0d", head_ray.hit, hit);
                        error_count++;
                    end
                    if (distance !== head_ray.distance)
                    begin
                        $error("distance: expected %0d actual %0d", head_ray.distance,
                               distance);
                        error_count++;
                    end
                end
            end
            if (stall_pos == 15)
            begin
                stall_pos = 0;
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 16'hFFFF;
                    1:       stall_pattern = 16'h0001;
                    default: stall_pattern = 16'($urandom) | 16'h0001;
                endcase
            end
            else
                stall_pos++;
            out_ready <= stall_pattern[stall_pos];
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("ray_march_box_hit_distance_unit verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_BOX_WRITE;
        box_index = '0;
        box_left = '0;
        box_top = '0;
        box_width = '0;
        box_height = '0;
        origin_x = '0;
        origin_y = '0;
        angle_code = '0;
        error_count = 0;
        burst_left = 0;
        cfg_step_size = STEP_SIZE_RST;
        cfg_step_count = STEP_COUNT_RST;
        cfg_box_count = BOX_COUNT_RST;
        for (int k = 0; k < ANGLE_STEPS; k++)
        begin
            sin_q14[k] = round_q14($sin(2.0 * PI * k / ANGLE_STEPS));
            cos_q14[k] = round_q14($cos(2.0 * PI * k / ANGLE_STEPS));
        end
        for (int j = 0; j < MAX_BOXES; j++)
            box_store[j] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_box_table();
        test_directed_rays();
        test_random_traffic();
        test_long_rays();

        wait_drained();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("ray_march_box_hit_distance_unit verification clean");
        else
            $display("ray_march_box_hit_distance_unit verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/rmbh_pkg.sv
rtl/rmbh_box_ram.sv
rtl/rmbh_dir.sv
rtl/rmbh_march.sv
rtl/ray_march_box_hit_distance_unit.sv
test/ray_march_box_hit_distance_unit_tb.sv
